/* rtl/core/fbfl_pkg.sv */
package fbfl_pkg;

    localparam int ADDR_W       = 24;
    localparam int HEADER_BYTES = 16;
    localparam int SHIFT_MIN    = 5;
    localparam int SHIFT_MAX    = 16;

    localparam logic [4:0] CHUNK_SHIFT_RST = 5'd6;
    localparam logic [8:0] BLOCK_COUNT_RST = 9'd256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] free_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

/* rtl/core/fbfl_ram.sv */
module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fixed_block_free_list_allocator.sv */
// Allocate, free and invalid or unused modes: the item is registered, then the
// result is registered in the execute state once the output is free, and no new
// item is taken before that. Pool reset item: one link entry rewritten per cycle.
// After aresetn, and after a config write to the chunk shift or block count, the
// link RAM is relinked while s_ready stays low; config writes are always taken.
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fbfl_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fbfl_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] NONE = LW'(MAX_BLOCKS);

    fbfl_pkg::state_t    state_reg, state_next;
    logic [4:0]          chunk_shift_reg, chunk_shift_next;
    logic [8:0]          block_count_reg, block_count_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;
    logic                clr_item_reg, clr_item_next;
    fbfl_pkg::in_item_t  item_reg, item_next;
    logic                m_valid_reg, m_valid_next;
    fbfl_pkg::out_item_t m_data_reg, m_data_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [LW-1:0]       ram_wdata, ram_rdata;

    logic [4:0]                    shift_eff;
    logic [LW-1:0]                 cnt_eff;
    logic [LW-1:0]                 clr_link;
    logic [fbfl_pkg::ADDR_W-1:0]   off, blk_full, low_mask;
    logic                          free_ok, out_free;

    fbfl_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_BLOCKS)
    ) u_link_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (chunk_shift_reg < 5'(fbfl_pkg::SHIFT_MIN)) begin
            shift_eff = 5'(fbfl_pkg::SHIFT_MIN);
        end else if (chunk_shift_reg > 5'(fbfl_pkg::SHIFT_MAX)) begin
            shift_eff = 5'(fbfl_pkg::SHIFT_MAX);
        end else begin
            shift_eff = chunk_shift_reg;
        end
        if (block_count_reg == 9'd0) begin
            cnt_eff = LW'(1);
        end else if (32'(block_count_reg) > 32'(MAX_BLOCKS)) begin
            cnt_eff = LW'(MAX_BLOCKS);
        end else begin
            cnt_eff = LW'(block_count_reg);
        end
    end

    assign clr_link = ((LW'(clr_idx_reg) + LW'(1)) < cnt_eff) ?
                      (LW'(clr_idx_reg) + LW'(1)) : NONE;

    assign off      = item_reg.free_address - fbfl_pkg::ADDR_W'(fbfl_pkg::HEADER_BYTES);
    assign blk_full = off >> shift_eff;
    assign low_mask = (fbfl_pkg::ADDR_W'(1) << shift_eff) - fbfl_pkg::ADDR_W'(1);
    assign free_ok  = (item_reg.free_address >= fbfl_pkg::ADDR_W'(fbfl_pkg::HEADER_BYTES))
                   && ((off & low_mask) == '0)
                   && (blk_full < fbfl_pkg::ADDR_W'(cnt_eff));
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbfl_pkg::ST_CLEAR;
            chunk_shift_reg <= fbfl_pkg::CHUNK_SHIFT_RST;
            block_count_reg <= fbfl_pkg::BLOCK_COUNT_RST;
            head_reg        <= '0;
            clr_idx_reg     <= '0;
            clr_item_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            chunk_shift_reg <= chunk_shift_next;
            block_count_reg <= block_count_next;
            head_reg        <= head_next;
            clr_idx_reg     <= clr_idx_next;
            clr_item_reg    <= clr_item_next;
            m_valid_reg     <= m_valid_next;
        end
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        chunk_shift_next = chunk_shift_reg;
        block_count_next = block_count_reg;
        head_next        = head_reg;
        clr_idx_next     = clr_idx_reg;
        clr_item_next    = clr_item_reg;
        item_next        = item_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = clr_idx_reg;
        ram_wdata        = clr_link;
        ram_re           = 1'b0;
        ram_raddr        = head_reg[AW-1:0];
        s_ready          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fbfl_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_idx_reg == AW'(MAX_BLOCKS - 1)) begin
                    head_next    = '0;
                    clr_idx_next = '0;
                    if (clr_item_reg) begin
                        clr_item_next = 1'b0;
                        state_next    = fbfl_pkg::ST_EXEC;
                    end else begin
                        state_next = fbfl_pkg::ST_IDLE;
                    end
                end else begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            fbfl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                    ram_re    = 1'b1;
                    if (s_data.mode == fbfl_pkg::MODE_RESET) begin
                        clr_item_next = 1'b1;
                        clr_idx_next  = '0;
                        head_next     = '0;
                        state_next    = fbfl_pkg::ST_CLEAR;
                    end else begin
                        state_next = fbfl_pkg::ST_EXEC;
                    end
                end
            end
            fbfl_pkg::ST_EXEC: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.alloc_address = '0;
                    m_data_next.status        = fbfl_pkg::STATUS_OK;
                    state_next                = fbfl_pkg::ST_IDLE;
                    case (item_reg.mode)
                        fbfl_pkg::MODE_ALLOC: begin
                            if (head_reg == NONE) begin
                                m_data_next.status = fbfl_pkg::STATUS_NO_FREE;
                            end else begin
                                m_data_next.alloc_address =
                                    (fbfl_pkg::ADDR_W'(head_reg) << shift_eff)
                                    + fbfl_pkg::ADDR_W'(fbfl_pkg::HEADER_BYTES);
                                head_next = ram_rdata;
                            end
                        end
                        fbfl_pkg::MODE_FREE: begin
                            if (free_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = blk_full[AW-1:0];
                                ram_wdata = head_reg;
                                head_next = LW'(blk_full);
                            end else begin
                                m_data_next.status = fbfl_pkg::STATUS_BAD_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = fbfl_pkg::ST_CLEAR;
            end
        endcase

        if (cfg_valid) begin
            if (cfg_index == fbfl_pkg::CFG_CHUNK_SHIFT) begin
                chunk_shift_next = cfg_wdata[4:0];
                state_next       = fbfl_pkg::ST_CLEAR;
                clr_idx_next     = '0;
                head_next        = '0;
            end else if (cfg_index == fbfl_pkg::CFG_BLOCK_COUNT) begin
                block_count_next = cfg_wdata[8:0];
                state_next       = fbfl_pkg::ST_CLEAR;
                clr_idx_next     = '0;
                head_next        = '0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on consecutive cycles");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != fbfl_pkg::STATUS_OK) |-> (m_data.alloc_address == '0))
        else $error("nonzero address with error status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NONE)
        else $error("free list head out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fbfl_pkg::ST_EXEC))
        else $error("result loaded outside execute");
`endif

endmodule
